// ----- rtl/windowed_valley_detector_macros.svh -----
// Assertion macros for the windowed valley detector.
// Used by the top level; expects clk and rst_n in the including scope.
`ifndef WINDOWED_VALLEY_DETECTOR_MACROS_SVH
`define WINDOWED_VALLEY_DETECTOR_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define WVD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define WVD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/wvd_pkg.sv -----
// Shared types and constants for the windowed valley detector.
// No dependencies; used by wvd_window_store and windowed_valley_detector.
`timescale 1ns / 1ps
`default_nettype none

package wvd_pkg;

  localparam int SAMPLE_W       = 16;
  localparam int CFG_DATA_W     = 16;
  localparam int CFG_IDX_W      = 2;
  localparam int WLEN_CFG_W     = 5;
  localparam int DEF_MAX_WINDOW = 16;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_FLOOR_LEVEL    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FLAT_TOLERANCE = 2'd2;

  localparam logic [SAMPLE_W-1:0]   FLOOR_RESET   = 16'hFFFF;
  localparam logic [WLEN_CFG_W-1:0] WLEN_RESET    = 5'd8;
  localparam logic [SAMPLE_W-1:0]   TOL_RESET     = 16'd10;
  localparam logic [SAMPLE_W-1:0]   VALLEY_RESET  = 16'hFFFF;
  localparam logic [SAMPLE_W-1:0]   COUNT_MAX     = 16'hFFFF;

  // Half-window slope limits, on differences one bit wider than a sample.
  localparam logic signed [SAMPLE_W:0] RISE_LIMIT = 17'sd20;
  localparam logic signed [SAMPLE_W:0] FALL_LIMIT = -17'sd20;

  // Control for one cycle of the window store.
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic advance;
  } store_cmd_t;

endpackage

`default_nettype wire

// ----- rtl/wvd_window_store.sv -----
// Window sample memory for the windowed valley detector: a circular buffer
// addressed by position from the oldest entry. Depends on wvd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wvd_window_store #(
  parameter int MAX_WINDOW = wvd_pkg::DEF_MAX_WINDOW
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire  wvd_pkg::store_cmd_t             cmd,
  input  wire  [((MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1)-1:0] wr_idx,
  input  wire  [wvd_pkg::SAMPLE_W-1:0]          wr_data,
  input  wire  [((MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1)-1:0] rd_idx,
  output logic [wvd_pkg::SAMPLE_W-1:0]          rd_data
);

  localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam logic [IDX_W:0] DEPTH = (IDX_W + 1)'(MAX_WINDOW);

  logic [wvd_pkg::SAMPLE_W-1:0] mem [MAX_WINDOW];
  logic [IDX_W-1:0]             head_r;
  logic [IDX_W-1:0]             head_nxt;
  logic [wvd_pkg::SAMPLE_W-1:0] rd_data_r;

  // Position from the oldest entry to physical address, wrapping once.
  function automatic logic [IDX_W-1:0] to_phys(input logic [IDX_W-1:0] base,
                                               input logic [IDX_W-1:0] pos);
    logic [IDX_W:0] sum;
    sum = {1'b0, base} + {1'b0, pos};
    if (sum >= DEPTH) begin
      sum = sum - DEPTH;
    end
    return sum[IDX_W-1:0];
  endfunction

  always_comb begin
    head_nxt = head_r;
    if (cmd.advance) begin
      head_nxt = to_phys(head_r, IDX_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
    end else begin
      head_r <= head_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[to_phys(head_r, wr_idx)] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[to_phys(head_r, rd_idx)];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ----- rtl/windowed_valley_detector.sv -----
// Windowed valley detector: top level, sequencer, valley records and ports.
// Depends on wvd_pkg, wvd_window_store and windowed_valley_detector_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

// Takes one transaction at a time on the in_ channel and returns exactly one
// result on the out_ channel per transaction. A clear command, and a sample
// whose window is not full before or after it, skip the flatness checks.
// Otherwise the window lives in a single-port sample memory, so the flatness
// check of the old window reads three entries and the check of the new
// window walks all W entries (W = window_length), one read per cycle,
// feeding one comparator that tracks the minimum. The result sits in an
// output register, so a stalled result does not hold up the next
// transaction's work; that transaction completes once the result is taken.
// Configuration writes are taken only while no transaction is in progress
// or offered. No clearing pass is needed after reset.
module windowed_valley_detector #(
  parameter int MAX_WINDOW = wvd_pkg::DEF_MAX_WINDOW
) (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             in_valid,
  output logic                            in_stall,
  input  wire                             in_cmd,
  input  wire  [wvd_pkg::SAMPLE_W-1:0]    in_sample,
  output logic                            out_valid,
  input  wire                             out_stall,
  output logic                            out_accepted,
  output logic                            out_valley_found,
  output logic [wvd_pkg::SAMPLE_W-1:0]    out_last_valley,
  output logic [wvd_pkg::SAMPLE_W-1:0]    out_previous_valley,
  output logic [wvd_pkg::SAMPLE_W-1:0]    out_lowest_valley,
  output logic [wvd_pkg::SAMPLE_W-1:0]    out_valley_count,
  input  wire                             cfg_valid,
  output logic                            cfg_ready,
  input  wire  [wvd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire  [wvd_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int SW    = wvd_pkg::SAMPLE_W;
  localparam int CNT_W = $clog2(MAX_WINDOW + 1);
  localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int K_W   = (IDX_W < 2) ? 2 : IDX_W;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_SCAN  = 7'b0000010,
    ST_WAIT  = 7'b0000100,
    ST_EVAL  = 7'b0001000,
    ST_PUSH  = 7'b0010000,
    ST_WRITE = 7'b0100000,
    ST_FINAL = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  logic [SW-1:0]    floor_r, floor_nxt;
  logic [SW-1:0]    tol_r, tol_nxt;
  logic [CNT_W-1:0] wlen_r, wlen_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic [K_W-1:0]   k_r, k_nxt;
  logic             post_r, post_nxt;
  logic             acc_r, acc_nxt;
  logic             found_r, found_nxt;
  logic [IDX_W-1:0] tag_r;
  logic             tag_vld_r;

  logic [SW-1:0] recent_r, recent_nxt;
  logic [SW-1:0] older_r, older_nxt;
  logic [SW-1:0] lowest_r, lowest_nxt;
  logic [SW-1:0] count_r, count_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          out_acc_r, out_acc_nxt;
  logic          out_found_r, out_found_nxt;

  logic          cmd_r;
  logic [SW-1:0] sample_r;
  logic [SW-1:0] first_r, mid_r, last_r, low_r;

  wvd_pkg::store_cmd_t store_cmd;
  logic [IDX_W-1:0]    rd_idx;
  logic [IDX_W-1:0]    wr_idx;
  logic [SW-1:0]       rd_data;

  logic [IDX_W-1:0] half_idx;
  logic [IDX_W-1:0] last_idx;
  logic             in_take;
  logic             cfg_take;
  logic             out_free;
  logic [SW:0]      rise_w, fall_w;
  logic [SW-1:0]    span;
  logic             flat;
  logic [31:0]      wlen_cfg;
  logic [CNT_W-1:0] wlen_clamped;

  assign half_idx = IDX_W'(wlen_r >> 1);
  assign last_idx = IDX_W'(wlen_r - CNT_W'(1));
  assign in_stall  = (state_r != ST_IDLE);
  // Hold a write off while a transaction is offered, so it never mixes with one.
  assign cfg_ready = (state_r == ST_IDLE) && !in_valid;
  assign in_take   = in_valid && !in_stall;
  assign cfg_take  = cfg_valid && cfg_ready;
  assign out_free  = !out_valid_r || !out_stall;

  // Hold the window length within 1..MAX_WINDOW.
  always_comb begin
    wlen_cfg = 32'(cfg_wdata[wvd_pkg::WLEN_CFG_W-1:0]);
    if (wlen_cfg == 32'd0) begin
      wlen_clamped = CNT_W'(1);
    end else if (wlen_cfg > 32'(MAX_WINDOW)) begin
      wlen_clamped = CNT_W'(MAX_WINDOW);
    end else begin
      wlen_clamped = CNT_W'(wlen_cfg);
    end
  end

  // Flatness of the captured first, middle and last entries.
  always_comb begin
    rise_w = {1'b0, mid_r} - {1'b0, first_r};
    fall_w = {1'b0, last_r} - {1'b0, mid_r};
    span   = (first_r > last_r) ? (first_r - last_r) : (last_r - first_r);
    flat   = (span <= tol_r)
          && ($signed(rise_w) < wvd_pkg::RISE_LIMIT)
          && ($signed(fall_w) > wvd_pkg::FALL_LIMIT);
  end

  always_comb begin
    state_nxt     = state_r;
    floor_nxt     = floor_r;
    tol_nxt       = tol_r;
    wlen_nxt      = wlen_r;
    fill_nxt      = fill_r;
    k_nxt         = k_r;
    post_nxt      = post_r;
    acc_nxt       = acc_r;
    found_nxt     = found_r;
    recent_nxt    = recent_r;
    older_nxt     = older_r;
    lowest_nxt    = lowest_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_acc_nxt   = out_acc_r;
    out_found_nxt = out_found_r;
    store_cmd     = '0;
    rd_idx        = '0;
    wr_idx        = IDX_W'(fill_r - CNT_W'(1));

    if (cfg_take) begin
      unique case (cfg_index)
        wvd_pkg::CFG_FLOOR_LEVEL:    floor_nxt = cfg_wdata;
        wvd_pkg::CFG_WINDOW_LENGTH: begin
          wlen_nxt = wlen_clamped;
          if (fill_r > wlen_clamped) begin
            fill_nxt = wlen_clamped;
          end
        end
        wvd_pkg::CFG_FLAT_TOLERANCE: tol_nxt = cfg_wdata;
        default: ;
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          acc_nxt   = 1'b0;
          found_nxt = 1'b0;
          k_nxt     = '0;
          post_nxt  = 1'b0;
          if (in_cmd) begin
            state_nxt = ST_FINAL;
          end else if (fill_r == wlen_r) begin
            state_nxt = ST_SCAN;
          end else if (in_sample <= floor_r) begin
            acc_nxt   = 1'b1;
            state_nxt = ST_PUSH;
          end else begin
            state_nxt = ST_FINAL;
          end
        end
      end
      ST_SCAN: begin
        store_cmd.rd_en = 1'b1;
        if (post_r) begin
          rd_idx = k_r[IDX_W-1:0];
          if (k_r == K_W'(last_idx)) begin
            state_nxt = ST_WAIT;
          end
        end else begin
          if (k_r == K_W'(0)) begin
            rd_idx = '0;
          end else if (k_r == K_W'(1)) begin
            rd_idx = half_idx;
          end else begin
            rd_idx = last_idx;
          end
          if (k_r == K_W'(2)) begin
            state_nxt = ST_WAIT;
          end
        end
        k_nxt = k_r + K_W'(1);
      end
      ST_WAIT: begin
        state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        if (post_r) begin
          found_nxt = flat;
          state_nxt = ST_FINAL;
        end else begin
          // A flat window restarts the fill, whether or not the sample goes in.
          if (flat) begin
            fill_nxt = '0;
          end
          if (sample_r <= floor_r) begin
            acc_nxt   = 1'b1;
            state_nxt = ST_PUSH;
          end else begin
            state_nxt = ST_FINAL;
          end
        end
      end
      ST_PUSH: begin
        if (fill_r >= wlen_r) begin
          store_cmd.advance = 1'b1;
          fill_nxt          = wlen_r;
        end else begin
          fill_nxt = fill_r + CNT_W'(1);
        end
        state_nxt = ST_WRITE;
      end
      ST_WRITE: begin
        store_cmd.wr_en = 1'b1;
        k_nxt           = '0;
        post_nxt        = 1'b1;
        state_nxt       = (fill_r == wlen_r) ? ST_SCAN : ST_FINAL;
      end
      ST_FINAL: begin
        if (out_free) begin
          if (cmd_r) begin
            recent_nxt = floor_r;
            older_nxt  = floor_r;
            lowest_nxt = floor_r;
            count_nxt  = '0;
            fill_nxt   = '0;
          end else if (found_r) begin
            older_nxt  = recent_r;
            recent_nxt = low_r;
            if (low_r < lowest_r) begin
              lowest_nxt = low_r;
            end
            if (count_r != wvd_pkg::COUNT_MAX) begin
              count_nxt = count_r + SW'(1);
            end
          end
          out_valid_nxt = 1'b1;
          out_acc_nxt   = acc_r;
          out_found_nxt = found_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      floor_r     <= wvd_pkg::FLOOR_RESET;
      tol_r       <= wvd_pkg::TOL_RESET;
      wlen_r      <= (32'(wvd_pkg::WLEN_RESET) > 32'(MAX_WINDOW)) ?
                     CNT_W'(MAX_WINDOW) : CNT_W'(wvd_pkg::WLEN_RESET);
      fill_r      <= '0;
      k_r         <= '0;
      post_r      <= 1'b0;
      acc_r       <= 1'b0;
      found_r     <= 1'b0;
      tag_vld_r   <= 1'b0;
      recent_r    <= wvd_pkg::VALLEY_RESET;
      older_r     <= wvd_pkg::VALLEY_RESET;
      lowest_r    <= wvd_pkg::VALLEY_RESET;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      out_acc_r   <= 1'b0;
      out_found_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      floor_r     <= floor_nxt;
      tol_r       <= tol_nxt;
      wlen_r      <= wlen_nxt;
      fill_r      <= fill_nxt;
      k_r         <= k_nxt;
      post_r      <= post_nxt;
      acc_r       <= acc_nxt;
      found_r     <= found_nxt;
      tag_vld_r   <= store_cmd.rd_en;
      recent_r    <= recent_nxt;
      older_r     <= older_nxt;
      lowest_r    <= lowest_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      out_acc_r   <= out_acc_nxt;
      out_found_r <= out_found_nxt;
    end
  end

  // Payload: latched transaction and entries captured from the read stream.
  always_ff @(posedge clk) begin
    tag_r <= rd_idx;
    if (in_take) begin
      cmd_r    <= in_cmd;
      sample_r <= in_sample;
    end
    if (tag_vld_r) begin
      if (tag_r == '0) begin
        first_r <= rd_data;
      end
      if (tag_r == half_idx) begin
        mid_r <= rd_data;
      end
      if (tag_r == last_idx) begin
        last_r <= rd_data;
      end
      if (post_r) begin
        if (tag_r == '0 || rd_data < low_r) begin
          low_r <= rd_data;
        end
      end
    end
  end

  wvd_window_store #(
    .MAX_WINDOW(MAX_WINDOW)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (store_cmd),
    .wr_idx  (wr_idx),
    .wr_data (sample_r),
    .rd_idx  (rd_idx),
    .rd_data (rd_data)
  );

  assign out_valid           = out_valid_r;
  assign out_accepted        = out_acc_r;
  assign out_valley_found    = out_found_r;
  assign out_last_valley     = recent_r;
  assign out_previous_valley = older_r;
  assign out_lowest_valley   = lowest_r;
  assign out_valley_count    = count_r;

`include "windowed_valley_detector_macros.svh"

  `WVD_ASSERT_IMP(a_fill_in_window, 1'b1, fill_r <= wlen_r, "fill count beyond window length")
  `WVD_ASSERT_NXT(a_busy_after_take, in_take, in_stall, "input not held off after a transaction")
  `WVD_ASSERT_IMP(a_result_from_final, $rose(out_valid_r), $past(state_r == ST_FINAL), "result raised outside final step")
  `WVD_ASSERT_IMP(a_found_needs_accept, out_valid_r && out_found_r, out_acc_r, "valley reported for a rejected sample")

endmodule

`default_nettype wire
